>>> design/arba_pkg.sv
`timescale 1ns / 1ps

package arba_pkg;

    localparam int ADDR_BITS_DEF      = 48;
    localparam int PAGE_SIZE_LOG2_DEF = 12;

    // fixed field widths
    localparam int FIELD_ADDR_W = 48;
    localparam int LOG2_W       = 6;
    localparam int EP_LOG2_W    = 4;
    localparam int FLAGS_W      = 4;
    localparam int CFG_IDX_W    = 3;

    // internal address math: 64-bit values plus one carry bit
    localparam int CALC_W = 65;

    localparam logic [EP_LOG2_W-1:0] EP_LOG2_RST = 4'd6;

    // opcodes
    localparam logic [1:0] OP_PLAIN    = 2'd0;
    localparam logic [1:0] OP_KERNEL   = 2'd1;
    localparam logic [1:0] OP_ENDPOINT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE_LOG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_READ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WRITE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_EXEC     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_DEVICE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_LOG    = 3'd6;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_PERM     = 3'd2,
        ST_REGION   = 3'd3,
        ST_NO_SPACE = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [FIELD_ADDR_W-1:0] req_size;
        logic [LOG2_W-1:0]       align_log2;
        logic                    want_read;
        logic                    want_write;
        logic                    want_exec;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [FIELD_ADDR_W-1:0] block_base;
        logic [LOG2_W-1:0]       block_size_log2;
        logic [FLAGS_W-1:0]      block_flags;
    } rsp_t;

endpackage

>>> design/aligned_region_bump_allocator.sv
`timescale 1ns / 1ps

// Pipeline: a request accepted into the input register moves on to the result
// register when the output advances, and m_valid follows the result register.
// Throughput: one request per cycle unless m_ready stalls the output; the used-bytes
// mark is updated in the same cycle the result is registered (round-up, add and compares).
// Reset (aresetn low, synchronous): both pipeline stages empty, used mark 0,
// region registers 0, endpoint size exponent 6.
module aligned_region_bump_allocator #(
    parameter int ADDR_BITS      = arba_pkg::ADDR_BITS_DEF,
    parameter int PAGE_SIZE_LOG2 = arba_pkg::PAGE_SIZE_LOG2_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  arba_pkg::req_t                      s_req,

    output logic                                m_valid,
    input  logic                                m_ready,
    output arba_pkg::rsp_t                      m_rsp,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arba_pkg::FIELD_ADDR_W-1:0]   cfg_data
);
    import arba_pkg::*;

    localparam logic [CALC_W-1:0] ADDR_MASK_W = (CALC_W'(1) << ADDR_BITS) - CALC_W'(1);
    localparam logic [CALC_W-1:0] SPACE_END_W = CALC_W'(1) << ADDR_BITS;
    localparam logic [6:0]        RLOG_MAX    = 7'(ADDR_BITS - 1);

    // configuration
    logic [FIELD_ADDR_W-1:0] base_reg;
    logic [LOG2_W-1:0]       size_log_reg;
    logic                    rd_reg, wr_reg, ex_reg, dev_reg;
    logic [EP_LOG2_W-1:0]    ep_log_reg;

    // pipeline
    logic                 in_valid_reg, in_valid_next;
    req_t                 in_req_reg, in_req_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_rsp_reg, out_rsp_next;
    logic [ADDR_BITS-1:0] used_reg, used_next;

    logic advance;

    // request decode
    logic [LOG2_W-1:0] plain_log;
    logic              plain_pow2;
    logic [LOG2_W-1:0] blk_log;
    logic [CALC_W-1:0] size_w;
    logic              want_rd, want_wr, want_ex;
    status_t           pre_status;

    // carve
    logic [6:0]        rlog;
    logic [CALC_W-1:0] rbase_w, rsize_w, region_end_w;
    logic [CALC_W-1:0] cur_w, amask_w, round_w, aligned_w, end_w, diff_w;
    logic              no_space;
    status_t           fin_status;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_rsp     = out_rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            size_log_reg <= '0;
            rd_reg       <= 1'b0;
            wr_reg       <= 1'b0;
            ex_reg       <= 1'b0;
            dev_reg      <= 1'b0;
            ep_log_reg   <= EP_LOG2_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_REGION_BASE:     base_reg     <= cfg_data;
                REG_REGION_SIZE_LOG: size_log_reg <= cfg_data[LOG2_W-1:0];
                REG_REGION_READ:     rd_reg       <= cfg_data[0];
                REG_REGION_WRITE:    wr_reg       <= cfg_data[0];
                REG_REGION_EXEC:     ex_reg       <= cfg_data[0];
                REG_REGION_DEVICE:   dev_reg      <= cfg_data[0];
                REG_ENDPOINT_LOG:    ep_log_reg   <= cfg_data[EP_LOG2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // one-hot size to exponent: each exponent bit ORs the size bits that carry it
    always_comb begin
        plain_log = '0;
        for (int i = 0; i < FIELD_ADDR_W; i++) begin
            if (in_req_reg.req_size[i]) begin
                plain_log = plain_log | LOG2_W'(i);
            end
        end
        plain_pow2 = (in_req_reg.req_size != '0) &&
                     ((in_req_reg.req_size &
                       (in_req_reg.req_size - FIELD_ADDR_W'(1))) == '0);
    end

    always_comb begin
        blk_log    = '0;
        want_rd    = 1'b0;
        want_wr    = 1'b0;
        want_ex    = 1'b0;
        pre_status = ST_BAD_SIZE;
        case (in_req_reg.opcode)
            OP_PLAIN: begin
                blk_log = plain_log;
                want_rd = in_req_reg.want_read;
                want_wr = in_req_reg.want_write;
                want_ex = in_req_reg.want_exec;
                if (!plain_pow2) begin
                    pre_status = ST_BAD_SIZE;
                end else if ((want_rd && !rd_reg) || (want_wr && !wr_reg) ||
                             (want_ex && !ex_reg)) begin
                    pre_status = ST_PERM;
                end else begin
                    pre_status = ST_OK;
                end
            end
            OP_KERNEL, OP_ENDPOINT: begin
                blk_log = (in_req_reg.opcode == OP_KERNEL) ? LOG2_W'(PAGE_SIZE_LOG2)
                                                           : LOG2_W'(ep_log_reg);
                want_rd = 1'b1;
                want_wr = 1'b1;
                pre_status = (dev_reg || !rd_reg || !wr_reg) ? ST_REGION : ST_OK;
            end
            default: begin
                pre_status = ST_BAD_SIZE;
            end
        endcase
        size_w = CALC_W'(1) << blk_log;
    end

    // plain blocks align to align_log2, kernel and endpoint objects to their own size
    always_comb begin
        logic [LOG2_W-1:0] align;
        align   = (in_req_reg.opcode == OP_PLAIN) ? in_req_reg.align_log2 : blk_log;
        rlog    = (7'(size_log_reg) > RLOG_MAX) ? RLOG_MAX : 7'(size_log_reg);
        rbase_w = CALC_W'(base_reg) & ADDR_MASK_W;
        rsize_w = CALC_W'(1) << rlog;
        region_end_w = rbase_w + rsize_w;
        amask_w = (CALC_W'(1) << align) - CALC_W'(1);

        cur_w     = rbase_w + CALC_W'(used_reg);
        round_w   = {1'b0, cur_w[CALC_W-2:0]} + amask_w;
        aligned_w = {1'b0, round_w[CALC_W-2:0] & ~amask_w[CALC_W-2:0]};
        end_w     = aligned_w + size_w;
        diff_w    = end_w - rbase_w;

        // carry out of 64 bits, past the address space, or past the region end
        no_space = cur_w[CALC_W-1] || round_w[CALC_W-1] ||
                   (aligned_w > ADDR_MASK_W) || (aligned_w > region_end_w) ||
                   (end_w > region_end_w) || (end_w > SPACE_END_W);

        fin_status = pre_status;
        if (pre_status == ST_OK && no_space) begin
            fin_status = ST_NO_SPACE;
        end
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_req_next    = in_req_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        used_next      = used_reg;

        if (s_ready) begin
            in_valid_next = s_valid;
            in_req_next   = s_req;
        end

        if (advance) begin
            out_valid_next = in_valid_reg;
            out_rsp_next.status = fin_status;
            if (fin_status == ST_OK) begin
                out_rsp_next.block_base      = aligned_w[FIELD_ADDR_W-1:0];
                out_rsp_next.block_size_log2 = blk_log;
                out_rsp_next.block_flags     = {want_ex, want_wr, want_rd, dev_reg};
                if (in_valid_reg) begin
                    used_next = diff_w[ADDR_BITS-1:0];
                end
            end else begin
                out_rsp_next.block_base      = '0;
                out_rsp_next.block_size_log2 = '0;
                out_rsp_next.block_flags     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_req_reg  <= in_req_next;
        out_rsp_reg <= out_rsp_next;
    end

endmodule

>>> design/arba_checker.sv
`timescale 1ns / 1ps

module arba_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input arba_pkg::rsp_t m_rsp
);
    import arba_pkg::*;

    // a failed request carries no block
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status != ST_OK) |->
            (m_rsp.block_base == '0 && m_rsp.block_size_log2 == '0 &&
             m_rsp.block_flags == '0))
        else $error("failed result carries block fields");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status <= ST_NO_SPACE))
        else $error("undefined status code");

    // a granted block never runs past the top of the address space
    a_grant_in_space: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == ST_OK) |->
            (((FIELD_ADDR_W+1)'(m_rsp.block_base) +
              ((FIELD_ADDR_W+1)'(1) << m_rsp.block_size_log2)) <=
             ((FIELD_ADDR_W+1)'(1) << FIELD_ADDR_W)))
        else $error("granted block runs past the address space");

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)))
        else $error("stalled result changed");

endmodule

bind aligned_region_bump_allocator arba_checker u_arba_checker (.*);
